// File: hw/rtl/tksi_pkg.sv
// Shared types and constants for the top-k sorted insert list.
package tksi_pkg;

  localparam int unsigned RANKS_DEF = 16;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned RRANK_W   = 4;
  localparam int unsigned ACTIVE_W  = 5;
  localparam int unsigned POS_W     = 5;

  localparam logic [KEY_W-1:0]    KEY_MAX    = 32'h7FFF_FFFF;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;

  localparam logic [ACTION_W-1:0] ACTION_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACTION_READ   = 2'd1;
  localparam logic [ACTION_W-1:0] ACTION_CLEAR  = 2'd2;

  // Command broadcast to every cell in the cycle a transaction is taken.
  typedef struct packed {
    logic                 ins;
    logic                 clr;
    logic [KEY_W-1:0]     key;
    logic [IDX_W-1:0]     idx;
    logic [RRANK_W-1:0]   rank;
  } cmd_t;

  // Status rippling from cell to cell along the row.
  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     rd_index;
    logic [KEY_W-1:0]     rd_value;
  } chain_t;

endpackage

// File: hw/rtl/tksi_cell.sv
// One rank of the sorted list: stored entry, compare, and shift from the neighbor.
module tksi_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned PW       = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tksi_pkg::cmd_t               cmd_i,
  input  logic [tksi_pkg::ACTIVE_W-1:0] active_ranks_i,
  input  logic [tksi_pkg::KEY_W-1:0]   prev_value_i,
  input  logic [tksi_pkg::IDX_W-1:0]   prev_index_i,
  input  tksi_pkg::chain_t             chain_i,
  input  logic [PW-1:0]                pos_i,
  output tksi_pkg::chain_t             chain_o,
  output logic [PW-1:0]                pos_o,
  output logic [tksi_pkg::KEY_W-1:0]   value_o,
  output logic [tksi_pkg::IDX_W-1:0]   index_o
);

  localparam logic [PW-1:0] MY_POS = PW'(CELL_IDX);

  logic [tksi_pkg::KEY_W-1:0] value_q, value_d;
  logic [tksi_pkg::IDX_W-1:0] index_q, index_d;
  logic                       active, gt, hit, shift, sel;

  assign active = 32'(CELL_IDX) < 32'(active_ranks_i);
  assign gt     = $signed(cmd_i.key) > $signed(value_q);
  assign hit    = cmd_i.ins && active && !chain_i.found && !gt;
  assign shift  = cmd_i.ins && active && chain_i.found;
  assign sel    = 32'(CELL_IDX) == 32'(cmd_i.rank);

  always_comb begin
    value_d = value_q;
    index_d = index_q;
    if (cmd_i.clr) begin
      value_d = tksi_pkg::KEY_MAX;
      index_d = '0;
    end else if (hit) begin
      value_d = cmd_i.key;
      index_d = cmd_i.idx;
    end else if (shift) begin
      value_d = prev_value_i;
      index_d = prev_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= tksi_pkg::KEY_MAX;
      index_q <= '0;
    end else begin
      value_q <= value_d;
      index_q <= index_d;
    end
  end

  // Pass the first-stop flag, the hit position and the read data down the row.
  always_comb begin
    chain_o.found    = chain_i.found || (active && !gt);
    chain_o.rd_index = chain_i.rd_index | (sel ? index_q : '0);
    chain_o.rd_value = chain_i.rd_value | (sel ? value_q : '0);
    pos_o            = pos_i | (hit ? MY_POS : '0);
  end

  assign value_o = value_q;
  assign index_o = index_q;

endmodule

// File: hw/rtl/top_k_sorted_insert.sv
// Top level of the top-k sorted insert list: cell row, command decode, output register.
//
// Keeps the active_ranks smallest signed 32-bit keys seen, in ascending order,
// each with a 16-bit index, in a row of RANKS cells. Every cell compares the
// incoming key with its own entry in parallel; a flag ripples down the row to
// find the first active cell whose key is not less than the new one, that
// cell takes the new entry and the active cells behind it take their
// neighbor's entry, so the last active entry drops out. An insert returns
// accepted and the position, or position RANKS (masked to 5 bits) when the
// entry is discarded. A read returns the entry at read_rank (zero when the
// rank is at or beyond RANKS); a clear refills every cell with key
// 0x7FFFFFFF and index 0. Action 3 does nothing and returns zeros. The block
// takes one transaction per clock cycle while ready and presents its result in the
// next cycle from an output register; the slave side stays ready while that
// register is empty or being drained. The clock period is set by the compare
// and the found-flag ripple across the row of cells. Write active_ranks only
// while no transaction is in flight.
//
// s_axis_tuser: action[1:0]
// s_axis_tdata: entry_index[15:0], entry_value[47:16], read_rank[51:48], zero[55:52]
// m_axis_tuser: accepted[0]
// m_axis_tdata: position[4:0], out_index[20:5], out_value[52:21], zero[55:53]
module top_k_sorted_insert #(
  parameter int unsigned RANKS = tksi_pkg::RANKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration: active_ranks
  input  logic                           cfg_we_i,
  input  logic [tksi_pkg::ACTIVE_W-1:0]  cfg_wdata_i,
  // slave side
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [55:0]                    s_axis_tdata_i,  // entry_index, entry_value, read_rank
  input  logic [tksi_pkg::ACTION_W-1:0]  s_axis_tuser_i,  // action
  // master side
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [55:0]                    m_axis_tdata_o,  // position, out_index, out_value
  output logic                           m_axis_tuser_o   // accepted
);

  localparam int unsigned PW = (RANKS > 1) ? $clog2(RANKS) : 1;
  localparam logic [tksi_pkg::POS_W-1:0] DISCARD_POS = tksi_pkg::POS_W'(RANKS);

  logic [tksi_pkg::ACTIVE_W-1:0] active_ranks_q;

  logic                            s_fire;
  tksi_pkg::cmd_t                  cmd;
  logic [tksi_pkg::ACTION_W-1:0]   action;

  tksi_pkg::chain_t                chain [RANKS+1];
  logic [PW-1:0]                   pos   [RANKS+1];
  logic [tksi_pkg::KEY_W-1:0]      value [RANKS+1];
  logic [tksi_pkg::IDX_W-1:0]      index [RANKS+1];

  logic                            out_valid_q;
  logic                            accepted_q, accepted_d;
  logic [tksi_pkg::POS_W-1:0]      position_q, position_d;
  logic [tksi_pkg::IDX_W-1:0]      out_index_q, out_index_d;
  logic [tksi_pkg::KEY_W-1:0]      out_value_q, out_value_d;

  // Configuration register; the user must write it only while idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_ranks_q <= tksi_pkg::ACTIVE_RST;
    end else if (cfg_we_i) begin
      active_ranks_q <= cfg_wdata_i;
    end
  end

  // Take a new transaction whenever the output register is free or draining.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign action          = s_axis_tuser_i;

  // Broadcast the command; the cells change state only on an accepted transaction.
  always_comb begin
    cmd.ins  = s_fire && (action == tksi_pkg::ACTION_INSERT);
    cmd.clr  = s_fire && (action == tksi_pkg::ACTION_CLEAR);
    cmd.idx  = s_axis_tdata_i[15:0];
    cmd.key  = s_axis_tdata_i[47:16];
    cmd.rank = s_axis_tdata_i[51:48];
  end

  // Head of the row: nothing found yet, no read data, no neighbor to shift from.
  assign chain[0] = '{found: 1'b0, rd_index: '0, rd_value: '0};
  assign pos[0]   = '0;
  assign value[0] = tksi_pkg::KEY_MAX;
  assign index[0] = '0;

  for (genvar k = 0; k < RANKS; k++) begin : g_cell
    tksi_cell #(
      .CELL_IDX (k),
      .PW       (PW)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (cmd),
      .active_ranks_i (active_ranks_q),
      .prev_value_i   (value[k]),
      .prev_index_i   (index[k]),
      .chain_i        (chain[k]),
      .pos_i          (pos[k]),
      .chain_o        (chain[k+1]),
      .pos_o          (pos[k+1]),
      .value_o        (value[k+1]),
      .index_o        (index[k+1])
    );
  end

  // Form the result from the row's outputs in the same cycle.
  always_comb begin
    accepted_d  = 1'b0;
    position_d  = '0;
    out_index_d = '0;
    out_value_d = '0;
    case (action)
      tksi_pkg::ACTION_INSERT: begin
        // the found flag at the tail is set exactly when some active cell took the entry
        accepted_d = chain[RANKS].found;
        position_d = chain[RANKS].found ? tksi_pkg::POS_W'(pos[RANKS]) : DISCARD_POS;
      end
      tksi_pkg::ACTION_READ: begin
        position_d  = tksi_pkg::POS_W'(cmd.rank);
        out_index_d = chain[RANKS].rd_index;
        out_value_d = chain[RANKS].rd_value;
      end
      default: begin
        // clear and the unused code report all zeros
      end
    endcase
  end

  // Output register: hold until taken, reload on every accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      accepted_q  <= accepted_d;
      position_q  <= position_d;
      out_index_q <= out_index_d;
      out_value_q <= out_value_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = accepted_q;
  assign m_axis_tdata_o  = {3'b000, out_value_q, out_index_q, position_q};

endmodule

// File: sim/top_k_sorted_insert_test.sv
// Testbench for the top-k sorted insert list: directed steps, then random traffic.
`timescale 1ns / 100ps

module top_k_sorted_insert_test;
  import tksi_pkg::*;

  localparam int unsigned LIST_LEN = RANKS_DEF;
  localparam logic [ACTION_W-1:0] ACTION_NONE = 2'd3;  // unused code, block must ignore it
  localparam logic [POS_W-1:0] POS_DISCARD = POS_W'(LIST_LEN);
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned HOLD_AFTER = 150;

  // One result transaction, as it leaves the master side.
  typedef struct packed {
    logic              accepted;
    logic [POS_W-1:0]  position;
    logic [IDX_W-1:0]  out_index;
    logic [KEY_W-1:0]  out_value;
  } outcome_t;

  // One line of the directed plan: either a write of active_ranks or a transaction.
  typedef struct packed {
    logic                 is_cfg;
    logic [ACTIVE_W-1:0]  cfg_val;
    logic [ACTION_W-1:0]  action;
    logic [IDX_W-1:0]     idx;
    logic [KEY_W-1:0]     key;
    logic [RRANK_W-1:0]   rank;
    logic                 typed;
    outcome_t             want;
  } step_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [ACTIVE_W-1:0]  cfg_wdata_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [55:0]          s_axis_tdata_i;
  logic [ACTION_W-1:0]  s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [55:0]          m_axis_tdata_o;
  logic                 m_axis_tuser_o;

  top_k_sorted_insert dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Shadow copy of the list, advanced at every accepted transaction, and of active_ranks.
  logic signed [KEY_W-1:0] kept_key [LIST_LEN];
  logic [IDX_W-1:0]        kept_idx [LIST_LEN];
  logic [ACTIVE_W-1:0]     active_cnt;

  outcome_t pending_results [$];  // expected results, oldest first
  step_t    plan [$];

  int unsigned sent_cnt;
  int unsigned checked_cnt;
  int unsigned fail_cnt;
  int unsigned kept_cnt;
  int unsigned dropped_cnt;
  int unsigned setting_cnt;
  int unsigned cycle_cnt;
  bit          calm_tx;
  bit          calm_rx;
  bit          held;

  always #4 clk_i = ~clk_i;

  // Refill every entry with the greatest key and index 0 (reset and clear).
  function automatic void refill_list();
    for (int k = 0; k < LIST_LEN; k++) begin
      kept_key[k] = KEY_MAX;
      kept_idx[k] = '0;
    end
  endfunction

  // Apply one transaction to the shadow list and return the result it must produce.
  function automatic outcome_t apply_to_list(logic [ACTION_W-1:0] action,
                                             logic [IDX_W-1:0] idx,
                                             logic signed [KEY_W-1:0] key,
                                             logic [RRANK_W-1:0] rank);
    outcome_t    r;
    int unsigned n;
    int unsigned pos;
    r = '0;
    // an active count above the storage size acts as the full list
    n = (active_cnt > LIST_LEN) ? LIST_LEN : active_cnt;
    case (action)
      ACTION_INSERT: begin
        // first active slot whose key is not less than the new one; equal keys stay behind
        pos = 0;
        while (pos < n && key > kept_key[pos]) pos++;
        if (pos < n) begin
          for (int j = n - 1; j > int'(pos); j--) begin
            kept_key[j] = kept_key[j-1];
            kept_idx[j] = kept_idx[j-1];
          end
          kept_key[pos] = key;
          kept_idx[pos] = idx;
          r.accepted = 1'b1;
          r.position = POS_W'(pos);
          kept_cnt++;
        end else begin
          r.position = POS_DISCARD;
          dropped_cnt++;
        end
      end
      ACTION_READ: begin
        // ranks beyond active_ranks still return what is stored there
        r.position  = POS_W'(rank);
        r.out_index = kept_idx[rank];
        r.out_value = kept_key[rank];
      end
      ACTION_CLEAR: refill_list();
      default: ;
    endcase
    return r;
  endfunction

  function automatic step_t step(logic [ACTION_W-1:0] action, logic [IDX_W-1:0] idx,
                                 logic [KEY_W-1:0] key, logic [RRANK_W-1:0] rank,
                                 logic typed, outcome_t want);
    step_t s;
    s = '0;
    s.action = action;
    s.idx    = idx;
    s.key    = key;
    s.rank   = rank;
    s.typed  = typed;
    s.want   = want;
    return s;
  endfunction

  function automatic step_t cfg_row(logic [ACTIVE_W-1:0] v);
    step_t s;
    s = '0;
    s.is_cfg  = 1'b1;
    s.cfg_val = v;
    return s;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Keys: a narrow band to force ties, the full range, the extremes, and neighbors of kept keys.
  function automatic logic [KEY_W-1:0] draw_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return KEY_W'(int'($urandom_range(0, 16)) - 8);
      4, 5, 6:    return $urandom;
      7: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return KEY_MAX;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      default: return kept_key[$urandom_range(0, LIST_LEN - 1)]
                      + KEY_W'(int'($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  // Offer one transaction after a random gap, hold it until taken, then log its expected result.
  task automatic send_item(logic [ACTION_W-1:0] action, logic [IDX_W-1:0] idx,
                           logic [KEY_W-1:0] key, logic [RRANK_W-1:0] rank,
                           logic typed, outcome_t want);
    int unsigned gap;
    outcome_t    predicted;
    gap = calm_tx ? 0 : gap_len();
    @(negedge clk_i);
    repeat (gap) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= action;
    s_axis_tdata_i  <= {4'b0, rank, key, idx};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = apply_to_list(action, idx, key, rank);
    // the typed-in value stands where it is obvious; the shadow list still advances
    pending_results.push_back(typed ? want : predicted);
    sent_cnt++;
  endtask

  // Write active_ranks once the block has drained: valid low, nothing outstanding.
  task automatic set_active(logic [ACTIVE_W-1:0] v);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    active_cnt = v;
    setting_cnt++;
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off so the block backs up.
  initial begin
    int unsigned stall_left;
    m_axis_tready_i = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) calm_rx = ~calm_rx;
      if (!held && sent_cnt >= HOLD_AFTER) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!calm_rx) stall_left = gap_len();
      end
    end
  end

  // Check every result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.accepted  = m_axis_tuser_o;
      got.position  = m_axis_tdata_o[4:0];
      got.out_index = m_axis_tdata_o[20:5];
      got.out_value = m_axis_tdata_o[52:21];
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: position %0d", got.position);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        checked_cnt++;
        if (got.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
          fail_cnt++;
        end
        if (got.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, got.position);
          fail_cnt++;
        end
        if (got.out_index !== want.out_index) begin
          $error("out_index: expected %0d, got %0d", want.out_index, got.out_index);
          fail_cnt++;
        end
        if (got.out_value !== want.out_value) begin
          $error("out_value: expected %0d, got %0d",
                 $signed(want.out_value), $signed(got.out_value));
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: far above the slowest correct run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [ACTIVE_W-1:0] settings [9];
    int unsigned         lengths [9];
    int unsigned         r;
    logic [ACTION_W-1:0] action;
    step_t               s;

    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = ACTION_INSERT;
    refill_list();
    active_cnt = ACTIVE_RST;

    // Directed plan: reset contents, extremes, ties, clear, unused action,
    // active count of zero, one, and above the storage size.
    plan.push_back(step(ACTION_READ, 16'hFFFF, 32'hFFFF_FFFF, 4'd0, 1'b1,
                        {1'b0, 5'd0, 16'd0, KEY_MAX}));
    plan.push_back(step(ACTION_READ, 16'hFFFF, 32'hFFFF_FFFF, 4'd15, 1'b1,
                        {1'b0, 5'd15, 16'd0, KEY_MAX}));
    plan.push_back(step(ACTION_NONE, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 1'b1, '0));
    plan.push_back(step(ACTION_INSERT, 16'hFFFF, 32'h8000_0000, 4'hF, 1'b1,
                        {1'b1, 5'd0, 16'd0, 32'd0}));
    plan.push_back(step(ACTION_INSERT, 16'h0000, KEY_MAX, 4'h0, 1'b1,
                        {1'b1, 5'd1, 16'd0, 32'd0}));
    plan.push_back(step(ACTION_INSERT, 16'd1, 32'd0, 4'd0, 1'b0, '0));
    plan.push_back(step(ACTION_INSERT, 16'd2, 32'd0, 4'd0, 1'b0, '0));
    plan.push_back(step(ACTION_INSERT, 16'd3, 32'hFFFF_FFFF, 4'd0, 1'b0, '0));
    plan.push_back(step(ACTION_READ, 16'd0, 32'd0, 4'd0, 1'b1,
                        {1'b0, 5'd0, 16'hFFFF, 32'h8000_0000}));
    plan.push_back(step(ACTION_READ, 16'd0, 32'd0, 4'd1, 1'b0, '0));
    plan.push_back(step(ACTION_READ, 16'd0, 32'd0, 4'd2, 1'b0, '0));
    plan.push_back(step(ACTION_READ, 16'd0, 32'd0, 4'd3, 1'b0, '0));
    plan.push_back(step(ACTION_READ, 16'd0, 32'd0, 4'd4, 1'b0, '0));
    plan.push_back(step(ACTION_CLEAR, 16'hFFFF, 32'h1234_5678, 4'd7, 1'b1, '0));
    plan.push_back(step(ACTION_READ, 16'd0, 32'd0, 4'd0, 1'b1,
                        {1'b0, 5'd0, 16'd0, KEY_MAX}));
    plan.push_back(cfg_row(5'd0));
    plan.push_back(step(ACTION_INSERT, 16'd5, 32'h8000_0000, 4'd0, 1'b1,
                        {1'b0, POS_DISCARD, 16'd0, 32'd0}));
    plan.push_back(step(ACTION_READ, 16'd0, 32'd0, 4'd0, 1'b1,
                        {1'b0, 5'd0, 16'd0, KEY_MAX}));
    plan.push_back(cfg_row(5'd1));
    plan.push_back(step(ACTION_INSERT, 16'd7, 32'd10, 4'd0, 1'b1,
                        {1'b1, 5'd0, 16'd0, 32'd0}));
    plan.push_back(step(ACTION_INSERT, 16'd8, 32'd20, 4'd0, 1'b1,
                        {1'b0, POS_DISCARD, 16'd0, 32'd0}));
    plan.push_back(step(ACTION_INSERT, 16'd9, 32'd10, 4'd0, 1'b1,
                        {1'b1, 5'd0, 16'd0, 32'd0}));
    plan.push_back(step(ACTION_READ, 16'd0, 32'd0, 4'd1, 1'b1,
                        {1'b0, 5'd1, 16'd0, KEY_MAX}));
    plan.push_back(cfg_row(5'd31));
    plan.push_back(step(ACTION_INSERT, 16'hAAAA, 32'hFFFF_FFFB, 4'd0, 1'b0, '0));
    plan.push_back(step(ACTION_READ, 16'd0, 32'd0, 4'd15, 1'b0, '0));

    // Random phases: several active_ranks settings, the extremes among them.
    settings = '{5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd16, 5'd9, 5'd2, 5'd16};
    lengths  = '{90, 60, 50, 70, 20, 90, 50, 40, 60};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      s = plan[i];
      if (s.is_cfg) set_active(s.cfg_val);
      else send_item(s.action, s.idx, s.key, s.rank, s.typed, s.want);
    end

    foreach (settings[p]) begin
      set_active(settings[p]);
      repeat (lengths[p]) begin
        if ($urandom_range(0, 39) == 0) calm_tx = ~calm_tx;
        r = $urandom_range(0, 99);
        if (r < 62)      action = ACTION_INSERT;
        else if (r < 95) action = ACTION_READ;
        else if (r < 97) action = ACTION_CLEAR;
        else             action = ACTION_NONE;
        // unused fields carry noise so every bit toggles
        send_item(action, IDX_W'($urandom), draw_key(), RRANK_W'($urandom), 1'b0, '0);
      end
    end

    // Drain: drop valid, wait for the last result, then a few quiet cycles.
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d transactions over %0d active_ranks settings, checked %0d results.",
             sent_cnt, setting_cnt, checked_cnt);
    $display("Inserts kept %0d, discarded %0d; one long receiver hold-off applied.",
             kept_cnt, dropped_cnt);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tksi_pkg.sv
hw/rtl/tksi_cell.sv
hw/rtl/top_k_sorted_insert.sv
sim/top_k_sorted_insert_test.sv
